### hdl/phtm_pkg.sv
// Shared types and constants for the polynomial hash with tent-map mixing.
package phtm_pkg;

   localparam logic [31:0] HASH_MULT = 32'd7919;
   localparam int FOLD_COUNT = 53;
   localparam int FOLDS_PER_STAGE = 4;
   localparam int FOLD_STAGES = (FOLD_COUNT + FOLDS_PER_STAGE - 1) / FOLDS_PER_STAGE;

   localparam int MID_DEPTH_DEFAULT = 4;
   localparam int OUT_DEPTH_DEFAULT = 16;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_INDEX_LSB = 2;
   localparam logic CSR_MIX_MODE = 1'b0;
   localparam logic [1:0] MIX_MODE_RESET = 2'd1;

   typedef enum logic [1:0] {
      MODE_RAW    = 2'd0,
      MODE_TENT   = 2'd1,
      MODE_DYADIC = 2'd2
   } mix_mode_type;

   typedef struct packed {
      logic        last;
      logic [31:0] product;
      logic [1:0]  mode;
   } mid_entry_type;

endpackage

### hdl/phtm_fifo.sv
// Small first-in first-out queue built from registers.
module phtm_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### hdl/phtm_front.sv
// Front end: takes bytes, keeps the running power and forms each byte's product.
module phtm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [7:0]               data_byte,
   input  logic                     has_byte,
   input  logic                     last,
   input  logic [1:0]               mix_mode,
   input  logic                     mid_full,
   output logic                     mid_push,
   output phtm_pkg::mid_entry_type  mid_entry
);

   logic        accept;
   logic [31:0] power_ff, power_in;
   logic [31:0] byte_ext;
   logic [31:0] power_next;

   assign accept     = push && !mid_full;
   assign byte_ext   = {{24{data_byte[7]}}, data_byte};
   assign power_next = power_ff * phtm_pkg::HASH_MULT;
   assign mid_push   = accept && (has_byte || last);

   always_comb begin
      mid_entry.last    = last;
      mid_entry.mode    = mix_mode;
      mid_entry.product = has_byte ? byte_ext * power_ff : 32'd0;
   end

   always_comb begin
      power_in = power_ff;
      if (accept) begin
         if (last) begin
            power_in = 32'd1;
         end else if (has_byte) begin
            power_in = power_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff <= 32'd1;
      end else begin
         power_ff <= power_in;
      end
   end

   a_power_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> power_ff == 32'd1)
      else $error("Power did not restart after the final byte of a string.");

   a_idle_not_queued: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> (has_byte || last) && !mid_full)
      else $error("An idle item or a blocked item entered the queue.");

endmodule

### hdl/phtm_back.sv
// Back end: accumulates products and runs the fold pipeline that finishes each hash.
module phtm_back #(
   parameter int OUT_DEPTH = phtm_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     mid_empty,
   input  phtm_pkg::mid_entry_type  mid_head,
   output logic                     mid_pop,
   input  logic                     rsp_done,
   output logic                     fold_valid,
   output logic [31:0]              fold_value
);

   localparam int STAGES = phtm_pkg::FOLD_STAGES;
   localparam int FPS = phtm_pkg::FOLDS_PER_STAGE;
   localparam int CREDIT_WIDTH = $clog2(OUT_DEPTH + 1);

   logic [31:0]             sum_ff, sum_in;
   logic [31:0]             sum_total;
   logic [CREDIT_WIDTH-1:0] outstanding_ff, outstanding_in;
   logic                    credit_ok;
   logic                    issue;
   logic                    stage_valid_ff [STAGES+1];
   logic                    stage_valid_in [STAGES+1];
   logic [31:0]             stage_value_ff [STAGES+1];
   logic [31:0]             stage_value_in [STAGES+1];
   logic [1:0]              stage_mode_ff  [STAGES+1];

   function automatic logic [31:0] fold_once(input logic [31:0] h, input logic [1:0] mode);
      logic        below;
      logic [31:0] r;
      below = !h[31] && (h[30:0] != '1);
      r = h;
      unique case (mode)
         phtm_pkg::MODE_TENT: begin
            r = below ? {h[30:0], 1'b0} : {~h[30:0], 1'b0};
         end
         phtm_pkg::MODE_DYADIC: begin
            r = below ? {h[30:0], 1'b0} : {h[30:0] + 31'd1, 1'b0};
         end
         default: begin
            r = h;
         end
      endcase
      return r;
   endfunction

   assign credit_ok  = outstanding_ff < CREDIT_WIDTH'(OUT_DEPTH);
   assign mid_pop    = !mid_empty && (!mid_head.last || credit_ok);
   assign issue      = mid_pop && mid_head.last;
   assign sum_total  = sum_ff + mid_head.product;
   assign fold_valid = stage_valid_ff[STAGES];
   assign fold_value = stage_value_ff[STAGES];

   always_comb begin
      sum_in = sum_ff;
      if (mid_pop) begin
         sum_in = mid_head.last ? 32'd0 : sum_total;
      end
   end

   always_comb begin
      outstanding_in = outstanding_ff;
      if (issue && !rsp_done) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_done && !issue) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_comb begin
      logic [31:0] h;
      stage_valid_in[0] = issue;
      stage_value_in[0] = sum_total;
      for (int s = 1; s <= STAGES; s++) begin
         h = stage_value_ff[s-1];
         for (int k = 0; k < FPS; k++) begin
            if ((s - 1) * FPS + k < phtm_pkg::FOLD_COUNT) begin
               h = fold_once(h, stage_mode_ff[s-1]);
            end
         end
         stage_valid_in[s] = stage_valid_ff[s-1];
         stage_value_in[s] = h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff         <= 32'd0;
         outstanding_ff <= '0;
         for (int s = 0; s <= STAGES; s++) begin
            stage_valid_ff[s] <= 1'b0;
         end
      end else begin
         sum_ff         <= sum_in;
         outstanding_ff <= outstanding_in;
         for (int s = 0; s <= STAGES; s++) begin
            stage_valid_ff[s] <= stage_valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_value_ff[0] <= stage_value_in[0];
      stage_mode_ff[0]  <= mid_head.mode;
      for (int s = 1; s <= STAGES; s++) begin
         stage_value_ff[s] <= stage_value_in[s];
         stage_mode_ff[s]  <= stage_mode_ff[s-1];
      end
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CREDIT_WIDTH'(OUT_DEPTH))
      else $error("More hashes in flight than the result queue can hold.");

   a_issue_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      issue |=> stage_valid_ff[0] && sum_ff == 32'd0)
      else $error("A finished string did not enter the fold pipeline.");

endmodule

### hdl/polynomial_hash_tent_map_mix.sv
// Top level of the polynomial rolling hash with tent-map or dyadic-map mixing.
// Bytes are taken one per cycle unless full is raised. Each byte's product with the
// running power is formed as it is taken and queued; the back end adds it to the sum
// and, on the final item of a string, sends the sum through a fold pipeline of
// FOLD_STAGES (14) stages, each doing up to four folds. Strings may follow one another
// without gaps. The result queue of OUT_DEPTH entries is reserved ahead by credit, so
// a slow reader stalls the back end and then the input, never the fold pipeline.
module polynomial_hash_tent_map_mix #(
   parameter int MID_DEPTH = phtm_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = phtm_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_has_byte,
   input  logic                                req_last,
   output logic                                empty,
   input  logic                                pop,
   output logic [31:0]                         rsp_hash_value,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [phtm_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int MID_WIDTH = $bits(phtm_pkg::mid_entry_type);

   logic [1:0]              mode_ff, mode_in;
   logic                    csr_write;
   logic                    csr_hit;
   logic                    mid_push;
   logic                    mid_pop;
   logic                    mid_full;
   logic                    mid_empty;
   phtm_pkg::mid_entry_type mid_entry;
   phtm_pkg::mid_entry_type mid_head;
   logic [MID_WIDTH-1:0]    mid_rdata;
   logic                    fold_valid;
   logic [31:0]             fold_value;
   logic                    out_full;
   logic                    rsp_done;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[phtm_pkg::CSR_INDEX_LSB] == phtm_pkg::CSR_MIX_MODE);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? {30'd0, mode_ff} : 32'd0;
   assign full      = mid_full;
   assign mid_head  = phtm_pkg::mid_entry_type'(mid_rdata);
   assign rsp_done  = pop && !empty;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write) begin
         mode_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= phtm_pkg::MIX_MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   phtm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_byte (req_data_byte),
      .has_byte  (req_has_byte),
      .last      (req_last),
      .mix_mode  (mode_ff),
      .mid_full  (mid_full),
      .mid_push  (mid_push),
      .mid_entry (mid_entry)
   );

   phtm_fifo #(
      .WIDTH (MID_WIDTH),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_entry),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   phtm_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mid_empty  (mid_empty),
      .mid_head   (mid_head),
      .mid_pop    (mid_pop),
      .rsp_done   (rsp_done),
      .fold_valid (fold_valid),
      .fold_value (fold_value)
   );

   phtm_fifo #(
      .WIDTH (32),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (fold_valid),
      .wdata (fold_value),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp_hash_value),
      .empty (empty)
   );

   a_no_result_overflow: assert property (@(posedge clock) disable iff (reset)
      !(fold_valid && out_full && !rsp_done))
      else $error("A finished hash arrived while the result queue was full.");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> mode_ff == $past(pwdata[1:0]))
      else $error("A mode register transfer was not stored.");

endmodule

### verif/tb_polynomial_hash_tent_map_mix.sv
// Self-checking testbench for the polynomial rolling hash with tent-map and dyadic-map mixing.
module tb_polynomial_hash_tent_map_mix;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [31:0] FOLD_PIVOT = 32'h7FFF_FFFF;
   localparam logic [phtm_pkg::CSR_ADDR_WIDTH-1:0] MIX_MODE_ADDR =
      {phtm_pkg::CSR_MIX_MODE, {phtm_pkg::CSR_INDEX_LSB{1'b0}}};
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTED = 10;

   logic                                clock;
   logic                                reset;
   logic                                push;
   logic                                full;
   logic [7:0]                          req_data_byte;
   logic                                req_has_byte;
   logic                                req_last;
   logic                                empty;
   logic                                pop;
   logic [31:0]                         rsp_hash_value;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [phtm_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0]                         pwdata;
   logic [31:0]                         prdata;
   logic                                pready;

   logic [31:0] expected_hashes[$];
   logic [31:0] string_sum;
   logic [31:0] string_power;
   logic [1:0]  active_mode;
   logic [31:0] wanted_hash;
   logic [3:0]  modes_hashed;
   int          failures;
   int          items_sent;
   int          strings_hashed;
   int          hashes_checked;
   int          quiet_cycles;
   bit          sender_idle_on;
   bit          reader_idle_on;
   bit          long_hold_req;

   polynomial_hash_tent_map_mix DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_last       (req_last),
      .empty          (empty),
      .pop            (pop),
      .rsp_hash_value (rsp_hash_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [31:0] finish_hash(input logic [31:0] sum, input logic [1:0] mode);
      logic [31:0] h;
      h = sum;
      if (mode == phtm_pkg::MODE_TENT || mode == phtm_pkg::MODE_DYADIC) begin
         for (int i = 0; i < phtm_pkg::FOLD_COUNT; i++) begin
            if (h < FOLD_PIVOT) begin
               h = h << 1;
            end else if (mode == phtm_pkg::MODE_TENT) begin
               h = (32'hFFFF_FFFF - h) << 1;
            end else begin
               h = (h - FOLD_PIVOT) << 1;
            end
         end
      end
      return h;
   endfunction

   task automatic report_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTED) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic absorb_item(input logic [7:0] data, input logic has, input logic fin);
      logic [31:0] extended;
      extended = {{24{data[7]}}, data};
      if (has) begin
         string_sum = string_sum + extended * string_power;
         string_power = string_power * phtm_pkg::HASH_MULT;
      end
      if (fin) begin
         expected_hashes.push_back(finish_hash(string_sum, active_mode));
         modes_hashed[active_mode] = 1'b1;
         strings_hashed++;
         string_sum = 32'd0;
         string_power = 32'd1;
      end
   endtask

   task automatic send_item(input logic [7:0] data, input logic has, input logic fin);
      @(negedge clock);
      if (sender_idle_on && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      push <= 1'b1;
      req_data_byte <= data;
      req_has_byte <= has;
      req_last <= fin;
      do @(posedge clock); while (full);
      absorb_item(data, has, fin);
      if (has || fin) begin
         items_sent++;
      end
   endtask

   task automatic send_random_string();
      int kind;
      int len;
      logic [7:0] data;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         return;
      end
      if (kind == 1) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         return;
      end
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
               0: data = 8'h00;
               1: data = 8'h7F;
               2: data = 8'h80;
               default: data = 8'hFF;
            endcase
         end else begin
            data = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_item(data, 1'b1, (i == len - 1) && kind != 2);
      end
      if (kind == 2) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      push <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
   endtask

   task automatic set_mix_mode(input logic [31:0] value);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= MIX_MODE_ADDR;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      active_mode = value[1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_mix_mode();
      @(negedge clock);
      push <= 1'b0;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= MIX_MODE_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {30'd0, active_mode}) begin
         report_failure($sformatf("mix_mode read expected %h got %h",
                                  {30'd0, active_mode}, prdata));
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_reset_value();
      check_mix_mode();
   endtask

   task automatic test_directed_cases();
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h7F, 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h12, 1'b1, 1'b0);
      send_item(8'hFE, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      set_mix_mode(phtm_pkg::MODE_RAW);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      set_mix_mode(phtm_pkg::MODE_DYADIC);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b1);
      send_item(8'h33, 1'b0, 1'b1);
      set_mix_mode(MODE_UNUSED);
      send_item(8'h80, 1'b1, 1'b1);
      check_mix_mode();
   endtask

   task automatic test_wide_write();
      set_mix_mode(32'hFFFF_FFFE);
      check_mix_mode();
      repeat (3) send_random_string();
      set_mix_mode(32'hFFFF_FFFD);
      check_mix_mode();
      repeat (3) send_random_string();
   endtask

   task automatic test_random_strings();
      logic [31:0] value;
      logic [1:0] phase_mode[6];
      int stop_at;
      phase_mode = '{phtm_pkg::MODE_RAW, MODE_UNUSED, phtm_pkg::MODE_TENT,
                     phtm_pkg::MODE_DYADIC,
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
      for (int p = 0; p < 6; p++) begin
         value = $urandom;
         value[1:0] = phase_mode[p];
         set_mix_mode(value);
         stop_at = items_sent + 30;
         while (items_sent < stop_at) send_random_string();
      end
   endtask

   task automatic test_output_backpressure();
      sender_idle_on = 1'b0;
      long_hold_req = 1'b1;
      repeat (60) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      wait_results_drained();
      sender_idle_on = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      repeat (6) send_random_string();
      wait_results_drained();
      repeat (6) send_random_string();
   endtask

   task automatic test_steady_stream();
      int stop_at;
      set_mix_mode(phtm_pkg::MODE_TENT);
      sender_idle_on = 1'b0;
      reader_idle_on = 1'b0;
      stop_at = items_sent + 40;
      while (items_sent < stop_at) send_random_string();
   endtask

   initial begin : result_reader
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            pop <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_req = 1'b0;
            pop <= 1'b1;
         end else if (reader_idle_on && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            pop <= 1'b1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_hashes.size() == 0) begin
            report_failure($sformatf("unexpected hash %h", rsp_hash_value));
         end else begin
            wanted_hash = expected_hashes.pop_front();
            hashes_checked++;
            if (rsp_hash_value !== wanted_hash) begin
               report_failure($sformatf("hash_value expected %h got %h",
                                        wanted_hash, rsp_hash_value));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("FAIL polynomial_hash_tent_map_mix");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_data_byte = 8'h00;
      req_has_byte = 1'b0;
      req_last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = 32'd0;
      string_sum = 32'd0;
      string_power = 32'd1;
      active_mode = phtm_pkg::MIX_MODE_RESET;
      modes_hashed = 4'd0;
      failures = 0;
      items_sent = 0;
      strings_hashed = 0;
      hashes_checked = 0;
      quiet_cycles = 0;
      sender_idle_on = 1'b1;
      reader_idle_on = 1'b1;
      long_hold_req = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_value();
      test_directed_cases();
      test_wide_write();
      test_random_strings();
      test_output_backpressure();
      test_pause_until_drained();
      test_steady_stream();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Hashed %0d strings from %0d items, %0d hashes checked, mode mask %b.",
               strings_hashed, items_sent, hashes_checked, modes_hashed);
      $display("Included random stalls, a long reader hold-off and a drained pause.");
      if (failures == 0) begin
         $display("PASS polynomial_hash_tent_map_mix");
      end else begin
         $display("%0d failures", failures);
         $display("FAIL polynomial_hash_tent_map_mix");
      end
      $finish;
   end

endmodule
